@@ rtl/core/gbc_pkg.sv @@
// ----------------------------------------------------------------------------
// gbc_pkg
// Shared types and constants of the glyph blit compositor.
// ----------------------------------------------------------------------------
package gbc_pkg;

    localparam int MAX_COLUMNS = 256;
    localparam int MAX_ROWS    = 64;
    localparam int STORE_DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int ROW_W       = $clog2(MAX_ROWS);

    localparam int LW_W = 9;
    localparam int LR_W = 7;
    localparam int WC_W = ($clog2(MAX_COLUMNS + 1) > LW_W) ? $clog2(MAX_COLUMNS + 1) : LW_W;
    localparam int HC_W = ($clog2(MAX_ROWS + 1) > LR_W) ? $clog2(MAX_ROWS + 1) : LR_W;
    localparam int SX_W = (WC_W + 1 > 11) ? WC_W + 1 : 11;
    localparam int SY_W = (HC_W + 1 > 10) ? HC_W + 1 : 10;
    localparam int PROD_W = ROW_W + WC_W;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_GLYPH = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [1:0] REG_LINE_WIDTH = 2'd0;
    localparam logic [1:0] REG_LINE_ROWS  = 2'd1;
    localparam logic [1:0] REG_MONO_MODE  = 2'd2;

    localparam logic [8:0] RST_LINE_WIDTH = 9'd256;
    localparam logic [6:0] RST_LINE_ROWS  = 7'd64;

    localparam logic [7:0] PIX_SET  = 8'hff;
    localparam logic [7:0] PIX_ZERO = 8'h00;
    localparam logic [7:0] MONO_MSB = 8'h80;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROW,
        ST_PIX,
        ST_GREY_WR,
        ST_READ,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [LW_W-1:0] line_width;
        logic [LR_W-1:0] line_rows;
        logic            mono_mode;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic signed [8:0] origin_x;
        logic signed [8:0] origin_y;
        logic [7:0]        src_col;
        logic [7:0]        src_row;
        logic [8:0]        glyph_width;
        logic [7:0]        src_byte;
        logic [13:0]       read_index;
    } item_t;

    typedef struct packed {
        logic              re;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } mem_req_t;

    typedef struct packed {
        logic       done;
        logic [7:0] pixel_value;
        logic [3:0] pixels_written;
    } result_t;

endpackage

@@ rtl/core/gbc_store.sv @@
// ----------------------------------------------------------------------------
// gbc_store
// Single-port pixel store, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module gbc_store (
    input  logic              aclk,
    input  gbc_pkg::mem_req_t req,
    output logic [7:0]        rdata
);
    import gbc_pkg::*;

    logic [7:0] mem [STORE_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re) begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/gbc_ctrl.sv @@
// ----------------------------------------------------------------------------
// gbc_ctrl
// Sequencer: clearing, clipping, address generation, read-modify-write and reads of the store.
// ----------------------------------------------------------------------------
module gbc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  gbc_pkg::cfg_t     cfg,
    input  logic              in_valid,
    input  gbc_pkg::item_t    in_item,
    output logic              in_ready,
    input  logic              out_free,
    input  logic [7:0]        rdata,
    output gbc_pkg::mem_req_t mem_req,
    output gbc_pkg::result_t  res
);
    import gbc_pkg::*;

    state_t state_reg, state_next;

    logic signed [8:0] ox_reg, ox_next;
    logic signed [8:0] oy_reg, oy_next;
    logic [7:0]        col_reg, col_next;
    logic [7:0]        row_reg, row_next;
    logic [8:0]        gw_reg, gw_next;
    logic [7:0]        byte_reg, byte_next;
    logic [2:0]        i_reg, i_next;
    logic              row_ok_reg, row_ok_next;
    logic [ADDR_W-1:0] row_base_reg, row_base_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [3:0]        count_reg, count_next;
    logic [7:0]        pix_reg, pix_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              clr_item_reg, clr_item_next;
    logic              rd_ok_reg, rd_ok_next;

    logic [WC_W-1:0]        w_eff;
    logic [HC_W-1:0]        h_eff;
    logic signed [SY_W-1:0] by_s;
    logic                   row_ok;
    logic [8:0]             gcol;
    logic signed [SX_W-1:0] bx_s;
    logic                   px_ok;
    logic [ADDR_W-1:0]      px_addr;
    logic                   mono_bit;
    logic                   clr_last;
    logic                   rd_in_range;

    always_comb begin
        w_eff = (WC_W'(cfg.line_width) > WC_W'(MAX_COLUMNS)) ? WC_W'(MAX_COLUMNS)
                                                             : WC_W'(cfg.line_width);
        h_eff = (HC_W'(cfg.line_rows) > HC_W'(MAX_ROWS)) ? HC_W'(MAX_ROWS)
                                                         : HC_W'(cfg.line_rows);
        by_s   = SY_W'(oy_reg) + SY_W'($signed({1'b0, row_reg}));
        row_ok = !by_s[SY_W-1] && ($unsigned(by_s) < SY_W'(h_eff));
        gcol   = {1'b0, col_reg} + 9'(i_reg);
        bx_s   = SX_W'(ox_reg) + SX_W'($signed({1'b0, gcol}));
        px_ok  = row_ok_reg && (gcol < gw_reg) && !bx_s[SX_W-1]
                 && ($unsigned(bx_s) < SX_W'(w_eff));
        px_addr  = row_base_reg + ADDR_W'(bx_s[COL_W-1:0]);
        mono_bit = |(byte_reg & (MONO_MSB >> i_reg));
        clr_last = (clr_cnt_reg == ADDR_W'(STORE_DEPTH - 1));
        rd_in_range = (32'(in_item.read_index) < 32'(STORE_DEPTH));
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_last) begin
                    state_next = clr_item_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_valid) begin
                    case (in_item.kind)
                        KIND_CLEAR: state_next = ST_CLEAR;
                        KIND_GLYPH: state_next = ST_ROW;
                        KIND_READ:  state_next = ST_READ;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end
            ST_ROW: state_next = ST_PIX;
            ST_PIX: begin
                if (cfg.mono_mode) begin
                    if (i_reg == 3'd7) begin
                        state_next = ST_DONE;
                    end
                end else begin
                    state_next = px_ok ? ST_GREY_WR : ST_DONE;
                end
            end
            ST_GREY_WR: state_next = ST_DONE;
            ST_READ:    state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        in_ready      = 1'b0;
        mem_req       = '0;
        res.done      = 1'b0;
        ox_next       = ox_reg;
        oy_next       = oy_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        gw_next       = gw_reg;
        byte_next     = byte_reg;
        i_next        = i_reg;
        row_ok_next   = row_ok_reg;
        row_base_next = row_base_reg;
        addr_next     = addr_reg;
        count_next    = count_reg;
        pix_next      = pix_reg;
        clr_cnt_next  = clr_cnt_reg;
        clr_item_next = clr_item_reg;
        rd_ok_next    = rd_ok_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                mem_req.we    = 1'b1;
                mem_req.addr  = clr_cnt_reg;
                mem_req.wdata = PIX_ZERO;
                clr_cnt_next  = clr_cnt_reg + 1'b1;
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    ox_next       = in_item.origin_x;
                    oy_next       = in_item.origin_y;
                    col_next      = in_item.src_col;
                    row_next      = in_item.src_row;
                    gw_next       = in_item.glyph_width;
                    byte_next     = in_item.src_byte;
                    i_next        = 3'd0;
                    count_next    = 4'd0;
                    pix_next      = PIX_ZERO;
                    clr_cnt_next  = '0;
                    clr_item_next = 1'b1;
                    rd_ok_next    = rd_in_range;
                    if (in_item.kind == KIND_READ) begin
                        mem_req.re   = 1'b1;
                        mem_req.addr = ADDR_W'(in_item.read_index);
                    end
                end
            end
            ST_ROW: begin
                row_ok_next   = row_ok;
                row_base_next = ADDR_W'(PROD_W'(by_s[ROW_W-1:0]) * PROD_W'(w_eff));
            end
            ST_PIX: begin
                if (cfg.mono_mode) begin
                    if (px_ok && mono_bit) begin
                        mem_req.we    = 1'b1;
                        mem_req.addr  = px_addr;
                        mem_req.wdata = PIX_SET;
                    end
                    count_next = count_reg + 4'(px_ok);
                    i_next     = i_reg + 3'd1;
                end else if (px_ok) begin
                    mem_req.re   = 1'b1;
                    mem_req.addr = px_addr;
                    addr_next    = px_addr;
                end
            end
            ST_GREY_WR: begin
                mem_req.we    = 1'b1;
                mem_req.addr  = addr_reg;
                mem_req.wdata = rdata | byte_reg;
                count_next    = 4'd1;
            end
            ST_READ: begin
                pix_next = rd_ok_reg ? rdata : PIX_ZERO;
            end
            ST_DONE: begin
                res.done = 1'b1;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
        res.pixel_value    = pix_reg;
        res.pixels_written = count_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            clr_item_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            clr_item_reg <= clr_item_next;
        end
    end

    always_ff @(posedge aclk) begin
        ox_reg       <= ox_next;
        oy_reg       <= oy_next;
        col_reg      <= col_next;
        row_reg      <= row_next;
        gw_reg       <= gw_next;
        byte_reg     <= byte_next;
        i_reg        <= i_next;
        row_ok_reg   <= row_ok_next;
        row_base_reg <= row_base_next;
        addr_reg     <= addr_next;
        count_reg    <= count_next;
        pix_reg      <= pix_next;
        rd_ok_reg    <= rd_ok_next;
    end

endmodule

@@ rtl/core/glyph_blit_or_compositor.sv @@
// ----------------------------------------------------------------------------
// glyph_blit_or_compositor
// ORs glyph bitmap bytes into an 8-bit pixel store with clipping; clears it and reads pixels.
// ----------------------------------------------------------------------------
// One beat in, one beat out. The pixel store is a single-port memory of
// MAX_COLUMNS * MAX_ROWS bytes (16384) doing one access per cycle, which sets
// the cost of every beat: a read beat reads the store as it is taken, a grey
// glyph beat steps through ROW, PIX and GREY_WR (skipping GREY_WR when its
// pixel is clipped), a mono glyph beat takes its eight pixels in turn in PIX
// (set pixels written as 0xff), and a clear beat writes one store entry per
// cycle. After reset the same clearing pass runs before the first input beat
// is taken; configuration writes are taken at any time. The output register
// lets the next beat start while a result waits on m_tready.
module glyph_blit_or_compositor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // origin_x[8:0], origin_y[17:9], src_col[25:18], src_row[33:26],
    // glyph_width[42:34], src_byte[50:43], read_index[64:51], zero[71:65]
    input  logic [71:0] s_tdata,
    // kind[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // pixel_value[7:0], pixels_written[11:8], zero[15:12]
    output logic [15:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data
);
    import gbc_pkg::*;

    cfg_t     cfg;
    item_t    item;
    mem_req_t mem_req;
    result_t  res;
    logic [7:0] rdata;
    logic       out_free;

    logic [LW_W-1:0] line_width_reg;
    logic [LR_W-1:0] line_rows_reg;
    logic            mono_mode_reg;
    logic            out_valid_reg;
    logic [7:0]      out_pixel_reg;
    logic [3:0]      out_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg <= RST_LINE_WIDTH;
            line_rows_reg  <= RST_LINE_ROWS;
            mono_mode_reg  <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_LINE_WIDTH: line_width_reg <= cfg_data;
                REG_LINE_ROWS:  line_rows_reg  <= cfg_data[LR_W-1:0];
                REG_MONO_MODE:  mono_mode_reg  <= cfg_data[0];
                default:        mono_mode_reg  <= mono_mode_reg;
            endcase
        end
    end

    assign cfg.line_width = line_width_reg;
    assign cfg.line_rows  = line_rows_reg;
    assign cfg.mono_mode  = mono_mode_reg;

    assign item.kind        = s_tuser;
    assign item.origin_x    = $signed(s_tdata[8:0]);
    assign item.origin_y    = $signed(s_tdata[17:9]);
    assign item.src_col     = s_tdata[25:18];
    assign item.src_row     = s_tdata[33:26];
    assign item.glyph_width = s_tdata[42:34];
    assign item.src_byte    = s_tdata[50:43];
    assign item.read_index  = s_tdata[64:51];

    assign out_free = !out_valid_reg || m_tready;

    gbc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .in_valid (s_tvalid),
        .in_item  (item),
        .in_ready (s_tready),
        .out_free (out_free),
        .rdata    (rdata),
        .mem_req  (mem_req),
        .res      (res)
    );

    gbc_store u_store (
        .aclk  (aclk),
        .req   (mem_req),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= res.done;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.done && out_free) begin
            out_pixel_reg <= res.pixel_value;
            out_count_reg <= res.pixels_written;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_count_reg, out_pixel_reg};

`ifndef ASSERT_OFF
    a_no_write_when_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !mem_req.we)
        else $error("store written while taking a new beat");

    a_one_field_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:0] == 8'd0 || m_tdata[11:8] == 4'd0))
        else $error("result carries both a pixel and a write count");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[11:8] <= 4'd8))
        else $error("write count above eight");

    a_clear_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> !s_tready)
        else $error("beat taken before the clearing pass");
`endif

endmodule
